// ===== rtl/core/rbs_pkg.sv =====
package rbs_pkg;

   // Strip and table sizes
   localparam int MAX_LEDS     = 64;
   localparam int SINE_ENTRIES = 256;
   localparam int SINE_BITS    = $clog2(SINE_ENTRIES);

   // Field and datapath widths
   localparam int PHASE_W     = 16;
   localparam int LED_COUNT_W = 7;
   localparam int COLOR_W     = 8;
   localparam int LED_IDX_W   = 6;
   localparam int CNT_W       = $clog2(MAX_LEDS + 1);
   localparam int IDX_W       = $clog2(MAX_LEDS);
   localparam int REM_W       = CNT_W + 1;
   localparam int LVL_W       = 7;
   localparam int PROD_W      = LVL_W + CNT_W;
   localparam int STEP_W      = $clog2(PROD_W + 1);
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 32;

   // Brightness constants
   localparam logic [LVL_W-1:0] STATIC_LEVEL = LVL_W'(48);
   localparam int               BREATH_PEAK  = 72;
   localparam logic [63:0]      ONE_Q30      = 64'h0000_0000_4000_0000;
   localparam logic [63:0]      HALF_PI_Q30  = 64'd1686629713;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LED_COUNT      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BREATHE_ENABLE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_NORM,
      ST_MUL,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] quot;
      logic [CNT_W-1:0]  rmd;
   } div_res_type;

   typedef logic [LVL_W-1:0] level_table_type [SINE_ENTRIES];

   // Breathing brightness per sine entry: floor(72 * s * s / 2^32),
   // s = (1 + sin) / 2 in Q0.16 from a fixed-point Taylor series
   function automatic level_table_type build_level_table();
      level_table_type tbl;
      logic [63:0] a;
      logic [63:0] u;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] h;
      logic [63:0] m;
      logic [63:0] sum;
      logic [63:0] s;
      logic [63:0] lv;
      logic [1:0]  quad;
      for (int i = 0; i < SINE_ENTRIES; i++) begin
         a    = (64'(i) << 32) / SINE_ENTRIES;
         quad = a[31:30];
         u    = {34'd0, a[29:0]};
         if (quad[0]) begin
            u = ONE_Q30 - u;
         end
         x  = (u * HALF_PI_Q30) >> 30;
         x2 = (x * x) >> 30;
         h  = ONE_Q30;
         h  = ONE_Q30 - (((x2 * h) >> 30) / 64'd110);
         h  = ONE_Q30 - (((x2 * h) >> 30) / 64'd72);
         h  = ONE_Q30 - (((x2 * h) >> 30) / 64'd42);
         h  = ONE_Q30 - (((x2 * h) >> 30) / 64'd20);
         h  = ONE_Q30 - (((x2 * h) >> 30) / 64'd6);
         m  = (x * h) >> 30;
         if (m > ONE_Q30) begin
            m = ONE_Q30;
         end
         sum = quad[1] ? (ONE_Q30 - m) : (ONE_Q30 + m);
         s   = (sum + 64'd16384) >> 15;
         if (s > 64'd65535) begin
            s = 64'd65535;
         end
         lv     = (64'(BREATH_PEAK) * s * s) >> 32;
         tbl[i] = lv[LVL_W-1:0];
      end
      return tbl;
   endfunction

   localparam level_table_type LEVEL_TABLE = build_level_table();

endpackage

// ===== rtl/core/rbs_div.sv =====
module rbs_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [rbs_pkg::PROD_W-1:0] dividend,
   input  logic [rbs_pkg::CNT_W-1:0]  divisor,
   output rbs_pkg::div_res_type       res
);
   import rbs_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [PROD_W-1:0] work_ff, work_in;
   logic [CNT_W-1:0]  prem_ff, prem_in;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;
   logic              fits;

   // One quotient bit per cycle: shift in the next dividend bit, try the subtract
   assign trial = {prem_ff, work_ff[PROD_W-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = (trial >= {1'b0, divisor});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      work_in = work_ff;
      prem_in = prem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(PROD_W);
         work_in = dividend;
         prem_in = '0;
      end else if (busy_ff) begin
         work_in = {work_ff[PROD_W-2:0], fits};
         prem_in = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      work_ff <= work_in;
      prem_ff <= prem_in;
   end

   assign res.done = done_ff;
   assign res.quot = work_ff;
   assign res.rmd  = prem_ff;

endmodule

// ===== rtl/core/rbs_phase.sv =====
module rbs_phase (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        tick,
   input  logic                        restart,
   input  logic                        breathe,
   input  logic [rbs_pkg::PHASE_W-1:0] phase_step,
   input  logic                        load,
   output logic [rbs_pkg::LVL_W-1:0]   level
);
   import rbs_pkg::*;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [LVL_W-1:0]   level_ff, level_in;

   // Advance the phase on a tick in breathing mode, optionally from zero
   always_comb begin
      phase_in = phase_ff;
      if (tick && breathe) begin
         phase_in = (restart ? '0 : phase_ff) + phase_step;
      end
   end

   // Look up the brightness from the updated phase
   always_comb begin
      level_in = level_ff;
      if (load) begin
         level_in = breathe ? LEVEL_TABLE[phase_ff[PHASE_W-1 -: SINE_BITS]] : STATIC_LEVEL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
      level_ff <= level_in;
   end

   assign level = level_ff;

endmodule

// ===== rtl/core/rainbow_breathing_strip_generator.sv =====
// Each word accepted on req_ is a tick and yields one frame of led_count
// words on rsp_ (clamped to 64 LEDs, none for a count of zero), in LED order
// with rsp_tlast on the final LED. After the tick a setup state loads the
// brightness. Each LED then passes through a state that checks the hue
// sector, taking a further step for each sector boundary crossed (at most
// five over a whole frame). It then forms the product and runs the bit-serial
// divider (fourteen quotient bits, one per cycle, then the done flag). A last
// state hands the word to the output register, and waits there while a
// finished word is held up by rsp_tready. req_tready is high only between
// frames; the last word of a frame may still wait in the output register
// while the next tick is taken. Registers are to be written through csr_
// only between frames, which the block itself does not enforce, and then
// take effect on the next tick.
module rainbow_breathing_strip_generator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [rbs_pkg::REQ_DATA_W-1:0]  req_tdata,  // [0] restart_phase
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rbs_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // led_index, red, green, blue
   output logic                            rsp_tlast,  // last_led
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rbs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rbs_pkg::CSR_DATA_W-1:0]  csr_data
);
   import rbs_pkg::*;

   // Configuration registers
   logic [LED_COUNT_W-1:0] led_count_ff;
   logic [PHASE_W-1:0]     phase_step_ff;
   logic                   breathe_ff;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  k_ff, k_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [2:0]        sector_ff, sector_in;
   logic [LVL_W-1:0]  level;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [LED_IDX_W-1:0] idx_ff, idx_in;
   logic [COLOR_W-1:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic              last_ff, last_in;

   logic              accept;
   logic              load_level;
   logic              div_start;
   logic              emit_fire;
   logic              out_free;
   logic              rem_over;
   logic              is_last;
   logic [PROD_W-1:0] product;
   div_res_type       div_res;
   logic [LVL_W-1:0]  t_val;
   logic [LVL_W-1:0]  q_val;
   logic [COLOR_W-1:0] v_c, t_c, q_c;

   assign csr_ready = 1'b1;
   assign accept    = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign rem_over  = (rem_ff >= {1'b0, count_ff});
   assign is_last   = ((CNT_W'(k_ff) + CNT_W'(1)) == count_ff);

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         led_count_ff  <= LED_COUNT_W'(8);
         phase_step_ff <= PHASE_W'(417);
         breathe_ff    <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LED_COUNT:      led_count_ff  <= csr_data[LED_COUNT_W-1:0];
            CSR_PHASE_STEP:     phase_step_ff <= csr_data[PHASE_W-1:0];
            CSR_BREATHE_ENABLE: breathe_ff    <= csr_data[0];
            default:            ;
         endcase
      end
   end

   rbs_phase u_phase (
      .clock      (clock),
      .reset      (reset),
      .tick       (accept),
      .restart    (req_tdata[0]),
      .breathe    (breathe_ff),
      .phase_step (phase_step_ff),
      .load       (load_level),
      .level      (level)
   );

   // Product for the hue fraction of this LED
   assign product = PROD_W'(level) * PROD_W'(rem_ff[CNT_W-1:0]);

   rbs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .divisor  (count_ff),
      .res      (div_res)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_LOAD;
         ST_LOAD: state_in = (count_ff == '0) ? ST_IDLE : ST_NORM;
         ST_NORM: if (!rem_over) state_in = ST_MUL;
         ST_MUL:  state_in = ST_DIV;
         ST_DIV:  if (div_res.done) state_in = ST_EMIT;
         ST_EMIT: if (out_free) state_in = is_last ? ST_IDLE : ST_NORM;
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      req_tready = 1'b0;
      load_level = 1'b0;
      div_start  = 1'b0;
      emit_fire  = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_LOAD: load_level = 1'b1;
         ST_MUL:  div_start  = 1'b1;
         ST_EMIT: emit_fire  = out_free;
         default: ;
      endcase
   end

   // Walk the LEDs: reduce the running 6k remainder, step the sector
   always_comb begin
      count_in  = count_ff;
      k_in      = k_ff;
      rem_in    = rem_ff;
      sector_in = sector_ff;
      if (accept) begin
         count_in = (32'(led_count_ff) > MAX_LEDS) ? CNT_W'(MAX_LEDS) : CNT_W'(led_count_ff);
      end
      if (load_level) begin
         k_in      = '0;
         rem_in    = '0;
         sector_in = '0;
      end else if (state_ff == ST_NORM && rem_over) begin
         rem_in    = rem_ff - {1'b0, count_ff};
         sector_in = sector_ff + 3'd1;
      end else if (emit_fire && !is_last) begin
         k_in   = k_ff + IDX_W'(1);
         rem_in = rem_ff + REM_W'(6);
      end
   end

   // Fraction t and its complement q = v - ceil(v * rem / count)
   assign t_val = div_res.quot[LVL_W-1:0];
   assign q_val = level - t_val - LVL_W'(div_res.rmd != '0);
   assign v_c   = COLOR_W'(level);
   assign t_c   = COLOR_W'(t_val);
   assign q_c   = COLOR_W'(q_val);

   // Load the output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      idx_in       = idx_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      last_in      = last_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         idx_in       = LED_IDX_W'(k_ff);
         last_in      = is_last;
         unique case (sector_ff)
            3'd0: begin red_in = v_c;  green_in = t_c;  blue_in = '0;  end
            3'd1: begin red_in = q_c;  green_in = v_c;  blue_in = '0;  end
            3'd2: begin red_in = '0;   green_in = v_c;  blue_in = t_c; end
            3'd3: begin red_in = '0;   green_in = q_c;  blue_in = v_c; end
            3'd4: begin red_in = t_c;  green_in = '0;   blue_in = v_c; end
            default: begin red_in = v_c; green_in = '0; blue_in = q_c; end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      count_ff  <= count_in;
      k_ff      <= k_in;
      rem_ff    <= rem_in;
      sector_ff <= sector_in;
      idx_ff    <= idx_in;
      red_ff    <= red_in;
      green_ff  <= green_in;
      blue_ff   <= blue_in;
      last_ff   <= last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {2'b00, blue_ff, green_ff, red_ff, idx_ff};

   // The remainder is fully reduced before the product is formed
   a_rem_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (rem_ff < {1'b0, count_ff} && sector_ff < 3'd6))
      else $error("hue remainder not reduced below LED count");

   // Divider only finishes while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> (state_ff == ST_DIV))
      else $error("divider result arrived outside the divide step");

   // A new word is only loaded when the previous one has gone
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> ($stable(rsp_tdata) && rsp_valid_ff))
      else $error("pending result word overwritten");

   // Brightness never exceeds the breathing peak
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (level < LVL_W'(BREATH_PEAK)))
      else $error("brightness out of range");

endmodule
